FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Define ASSERT_OFF to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/yrh_pkg.sv
// ---------------------------------------------------------------------------
// yrh_pkg
// Types and constants for the yaw rate hold PID.
// ---------------------------------------------------------------------------
package yrh_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_ENABLE    = 4'd0,
    CFG_GAIN_P         = 4'd1,
    CFG_GAIN_I         = 4'd2,
    CFG_GAIN_D         = 4'd3,
    CFG_INTEGRAL_LIMIT = 4'd4,
    CFG_OUTPUT_LIMIT   = 4'd5,
    CFG_STOP_PULSES    = 4'd6,
    CFG_TURN_THRESHOLD = 4'd7
  } cfg_idx_t;

  // register reset values
  localparam logic        RST_HOLD_ENABLE    = 1'b1;
  localparam logic [15:0] RST_GAIN_P         = 16'd6144;
  localparam logic [15:0] RST_GAIN_I         = 16'd2458;
  localparam logic [15:0] RST_GAIN_D         = 16'd410;
  localparam logic [20:0] RST_INTEGRAL_LIMIT = 21'd629146;
  localparam logic [14:0] RST_OUTPUT_LIMIT   = 15'd6144;
  localparam logic [15:0] RST_STOP_PULSES    = 16'd3;
  localparam logic [14:0] RST_TURN_THRESHOLD = 15'd82;

  // 0.025 s tick in Q2.20 per Q4.12 LSB, scaled by 256
  localparam logic signed [11:0] INC_MUL      = 12'sd1638;
  // 0.00175 rad/s deadzone on the P term
  localparam logic signed [16:0] DEADZONE_LSB = 17'sd7;
  // rad to deg, Q20 -> Q8 with a 24-bit shift
  localparam logic signed [18:0] DEG_MUL      = 19'sd234685;

  typedef struct packed {
    logic signed [15:0] yaw_rate;
    logic               rate_valid;
    logic signed [15:0] turn_command;
    logic        [15:0] wheel_pulse_sum;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] correction;
    logic signed [15:0] angle_error_deg;
    logic               engaged;
  } out_item_t;

endpackage

FILE: sv/yaw_rate_hold_pid.sv
// Yaw rate hold PID: an input transfer reaches out_valid through these registers
// (input register, PID/state register, degree-conversion output register).
// Throughput is one item per cycle while out_ready is not stalling; the integral
// -> gain_i multiply -> output clamp -> anti-windup loop closes combinationally on
// the state register. Synchronous active-low reset clears the pipeline and state
// and loads the register defaults.
// ---------------------------------------------------------------------------
// yaw_rate_hold_pid
// Heading hold PID with integral clamp, deadzone and anti-windup.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module yaw_rate_hold_pid (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  yrh_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output yrh_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [yrh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [yrh_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // configuration registers
  logic        hold_en_r;
  logic [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [20:0] int_lim_r;
  logic [14:0] out_lim_r;
  logic [15:0] stop_pulses_r;
  logic [14:0] turn_thr_r;

  // state
  logic signed [21:0] integral_r, integral_nxt;
  logic signed [16:0] prev_err_r, prev_err_nxt;

  // pipeline
  logic               s0_v_r, s0_dis_r;
  logic signed [16:0] s0_err_r, s0_pe_r;
  logic signed [18:0] s0_inc_r;
  logic               s1_v_r, s1_eng_r;
  logic signed [15:0] s1_corr_r;
  logic signed [21:0] s1_int_r;
  yrh_pkg::out_item_t out_r;
  logic               out_v_r;

  logic s2_free, s1_free, s0_free, in_xfer, s1_load, s2_load, cfg_xfer, cfg_clear;

  function automatic logic signed [21:0] clamp_int(input logic signed [22:0] v,
                                                   input logic signed [22:0] lim);
    logic signed [21:0] res;
    if (v > lim) begin
      res = lim[21:0];
    end else if (v < -lim) begin
      res = 22'(-lim);
    end else begin
      res = v[21:0];
    end
    return res;
  endfunction

  // ---------------- handshake ----------------
  assign s2_free   = !out_v_r || out_ready;
  assign s1_free   = !s1_v_r || s2_free;
  assign s0_free   = !s0_v_r || s1_free;
  assign in_ready  = s0_free && rst_n;
  assign in_xfer   = in_valid && in_ready;
  assign s1_load   = s0_v_r && s1_free;
  assign s2_load   = s1_v_r && s2_free;
  assign cfg_ready = rst_n;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_xfer && (yrh_pkg::cfg_idx_t'(cfg_index) == yrh_pkg::CFG_HOLD_ENABLE)
                     && !cfg_data[0];

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_en_r     <= yrh_pkg::RST_HOLD_ENABLE;
      gain_p_r      <= yrh_pkg::RST_GAIN_P;
      gain_i_r      <= yrh_pkg::RST_GAIN_I;
      gain_d_r      <= yrh_pkg::RST_GAIN_D;
      int_lim_r     <= yrh_pkg::RST_INTEGRAL_LIMIT;
      out_lim_r     <= yrh_pkg::RST_OUTPUT_LIMIT;
      stop_pulses_r <= yrh_pkg::RST_STOP_PULSES;
      turn_thr_r    <= yrh_pkg::RST_TURN_THRESHOLD;
    end else if (cfg_xfer) begin
      case (yrh_pkg::cfg_idx_t'(cfg_index))
        yrh_pkg::CFG_HOLD_ENABLE:    hold_en_r     <= cfg_data[0];
        yrh_pkg::CFG_GAIN_P:         gain_p_r      <= cfg_data[15:0];
        yrh_pkg::CFG_GAIN_I:         gain_i_r      <= cfg_data[15:0];
        yrh_pkg::CFG_GAIN_D:         gain_d_r      <= cfg_data[15:0];
        yrh_pkg::CFG_INTEGRAL_LIMIT: int_lim_r     <= cfg_data[20:0];
        yrh_pkg::CFG_OUTPUT_LIMIT:   out_lim_r     <= cfg_data[14:0];
        yrh_pkg::CFG_STOP_PULSES:    stop_pulses_r <= cfg_data[15:0];
        yrh_pkg::CFG_TURN_THRESHOLD: turn_thr_r    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- input stage ----------------
  logic signed [16:0] turn_ext, err_in, pe_in;
  logic        [16:0] turn_mag;
  logic signed [26:0] inc_prod;
  logic               dis_in;

  always_comb begin
    turn_ext = 17'(in_data.turn_command);
    turn_mag = turn_ext[16] ? 17'(-turn_ext) : 17'(turn_ext);
    dis_in   = !hold_en_r || !in_data.rate_valid ||
               (in_data.wheel_pulse_sum < stop_pulses_r) ||
               (turn_mag > {2'b00, turn_thr_r});
    err_in   = -(17'(in_data.yaw_rate));
    inc_prod = 27'(err_in) * 27'(yrh_pkg::INC_MUL);
    pe_in    = (err_in > yrh_pkg::DEADZONE_LSB || err_in < -yrh_pkg::DEADZONE_LSB)
               ? err_in : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_free) begin
      s0_v_r <= in_valid;
    end
    if (in_xfer) begin
      s0_dis_r <= dis_in;
      s0_err_r <= err_in;
      s0_pe_r  <= pe_in;
      s0_inc_r <= inc_prod[26:8];
    end
  end

  // ---------------- PID stage ----------------
  logic signed [22:0] lim_i, int_sum;
  logic signed [21:0] int_clamp, int_undo, int_fin;
  logic signed [17:0] diff;
  logic signed [33:0] p_prod;
  logic signed [34:0] d_prod;
  logic signed [38:0] i_prod;
  logic signed [35:0] pid_sum;
  logic signed [23:0] sum_sh, lim_o24;
  logic signed [15:0] lim_o16, corr, corr_fin;
  logic               sat;

  always_comb begin
    lim_i     = signed'({2'b00, int_lim_r});
    int_sum   = 23'(integral_r) + 23'(s0_inc_r);
    int_clamp = clamp_int(int_sum, lim_i);
    diff      = 18'(s0_err_r) - 18'(prev_err_r);
    p_prod    = 34'(signed'({1'b0, gain_p_r})) * 34'(s0_pe_r);
    d_prod    = 35'(signed'({1'b0, gain_d_r})) * 35'(diff);
    i_prod    = 39'(signed'({1'b0, gain_i_r})) * 39'(int_clamp);
    pid_sum   = 36'(p_prod) + 36'(d_prod) + 36'(signed'(i_prod[38:8]));
    sum_sh    = pid_sum[35:12];
    lim_o24   = signed'({9'd0, out_lim_r});
    lim_o16   = signed'({1'b0, out_lim_r});
    if (sum_sh > lim_o24) begin
      corr = lim_o16;
    end else if (sum_sh < -lim_o24) begin
      corr = -lim_o16;
    end else begin
      corr = sum_sh[15:0];
    end
    // output pinned in the direction of the error: drop this tick's integration
    sat = (corr >= lim_o16 && s0_err_r > 17'sd0) ||
          (corr <= -lim_o16 && s0_err_r < 17'sd0);
    int_undo = clamp_int(23'(int_clamp) - 23'(s0_inc_r), lim_i);
    int_fin  = sat ? int_undo : int_clamp;

    integral_nxt = s0_dis_r ? '0 : int_fin;
    prev_err_nxt = s0_dis_r ? '0 : s0_err_r;
    corr_fin     = s0_dis_r ? '0 : corr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_err_r <= '0;
      s1_v_r     <= 1'b0;
    end else begin
      if (cfg_clear) begin
        integral_r <= '0;
        prev_err_r <= '0;
      end else if (s1_load) begin
        integral_r <= integral_nxt;
        prev_err_r <= prev_err_nxt;
      end
      if (s1_free) begin
        s1_v_r <= s0_v_r;
      end
    end
    if (s1_load) begin
      s1_corr_r <= corr_fin;
      s1_int_r  <= integral_nxt;
      s1_eng_r  <= !s0_dis_r;
    end
  end

  // ---------------- degree conversion / output register ----------------
  logic signed [40:0] deg_prod;

  assign deg_prod = 41'(s1_int_r) * 41'(yrh_pkg::DEG_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_free) begin
      out_v_r <= s1_v_r;
    end
    if (s2_load) begin
      out_r.correction      <= s1_corr_r;
      out_r.angle_error_deg <= deg_prod[39:24];
      out_r.engaged         <= s1_eng_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // ---------------- assertions ----------------
  logic signed [15:0] out_lim_s;
  assign out_lim_s = signed'({1'b0, out_lim_r});

  `ASSERT_IMPLY(a_bypass_zero, clk, rst_n, out_valid && !out_data.engaged, out_data.correction == '0 && out_data.angle_error_deg == '0)
  `ASSERT_IMPLY(a_corr_limit, clk, rst_n, out_valid && out_data.engaged, out_data.correction <= out_lim_s && out_data.correction >= -out_lim_s)
  `ASSERT_NEXT(a_bypass_clears, clk, rst_n, s1_load && s0_dis_r, integral_r == '0 && prev_err_r == '0)

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the yaw rate hold PID: a directed table, then random
// control ticks over several register settings, each result checked against its
// table entry or a cycle-free predictor of the integral, deadzone, clamps and anti-windup.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY      = 3;
  localparam int RANDOM_TICKS = 450;
  localparam int PHASES       = 6;
  localparam logic [yrh_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd15;

  // heading increment per tick, P deadzone, rad->deg scale
  localparam longint TICK_INC_MUL = 1638;
  localparam longint P_DEADBAND   = 7;
  localparam longint RAD_TO_DEG   = 234685;

  typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    yrh_pkg::in_item_t              tick;
    bit                             typed;
    yrh_pkg::out_item_t             want;
    logic [yrh_pkg::CFG_IDX_W-1:0]  idx;
    logic [yrh_pkg::CFG_DATA_W-1:0] data;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  yrh_pkg::in_item_t in_data;
  logic out_valid, out_ready;
  yrh_pkg::out_item_t out_data;
  logic cfg_valid, cfg_ready;
  logic [yrh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [yrh_pkg::CFG_DATA_W-1:0] cfg_data;

  // register shadow and controller state
  bit hold_en;
  bit [15:0] kp, ki, kd, stop_lim;
  bit [20:0] int_lim;
  bit [14:0] out_lim, turn_lim;
  longint heading_int, last_err;

  yrh_pkg::out_item_t expected_outs[$];
  yrh_pkg::out_item_t oldest;
  bit no_gaps;
  int yaw_walk;
  int mismatches, ticks_sent, results_seen, engaged_seen, cfg_writes;

  yaw_rate_hold_pid DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic yrh_pkg::out_item_t predict_tick(yrh_pkg::in_item_t t);
    longint rate, turn, err, inc, pe, sum, corr, lim_i, lim_o, deg;
    yrh_pkg::out_item_t r;
    r = '0;
    rate = longint'($signed(t.yaw_rate));
    turn = longint'($signed(t.turn_command));
    if (turn < 0) turn = -turn;
    if (!hold_en || !t.rate_valid || t.wheel_pulse_sum < stop_lim ||
        turn > longint'(turn_lim)) begin
      heading_int = 0;
      last_err = 0;
      return r;
    end
    lim_i = longint'(int_lim);
    lim_o = longint'(out_lim);
    err = -rate;
    inc = (err * TICK_INC_MUL) >>> 8;
    heading_int = clamp_sym(heading_int + inc, lim_i);
    pe = (err > P_DEADBAND || err < -P_DEADBAND) ? err : 0;
    sum = longint'(kp) * pe + longint'(kd) * (err - last_err)
        + ((longint'(ki) * heading_int) >>> 8);
    corr = clamp_sym(sum >>> 12, lim_o);
    last_err = err;
    // anti-windup: saturated toward the error, so drop this tick's increment
    if ((corr >= lim_o && err > 0) || (corr <= -lim_o && err < 0))
      heading_int = clamp_sym(heading_int - inc, lim_i);
    deg = (heading_int * RAD_TO_DEG) >>> 24;
    r.correction      = corr[15:0];
    r.angle_error_deg = deg[15:0];
    r.engaged         = 1'b1;
    return r;
  endfunction

  function automatic void apply_cfg(logic [yrh_pkg::CFG_IDX_W-1:0] idx,
                                    logic [yrh_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      yrh_pkg::CFG_HOLD_ENABLE: begin
        hold_en = d[0];
        if (!d[0]) begin
          heading_int = 0;
          last_err = 0;
        end
      end
      yrh_pkg::CFG_GAIN_P:         kp = d[15:0];
      yrh_pkg::CFG_GAIN_I:         ki = d[15:0];
      yrh_pkg::CFG_GAIN_D:         kd = d[15:0];
      yrh_pkg::CFG_INTEGRAL_LIMIT: int_lim = d[20:0];
      yrh_pkg::CFG_OUTPUT_LIMIT:   out_lim = d[14:0];
      yrh_pkg::CFG_STOP_PULSES:    stop_lim = d[15:0];
      yrh_pkg::CFG_TURN_THRESHOLD: turn_lim = d[14:0];
      default: ;
    endcase
  endfunction

  function automatic dir_row_t tick_row(int yaw, bit vld, int turn, int pulses,
                                        bit typed = 1'b0, int corr = 0, int deg = 0,
                                        bit eng = 1'b0);
    dir_row_t r;
    r.kind = ROW_TICK;
    r.tick.yaw_rate = 16'(yaw);
    r.tick.rate_valid = vld;
    r.tick.turn_command = 16'(turn);
    r.tick.wheel_pulse_sum = 16'(pulses);
    r.typed = typed;
    r.want.correction = 16'(corr);
    r.want.angle_error_deg = 16'(deg);
    r.want.engaged = eng;
    r.idx = '0;
    r.data = '0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [yrh_pkg::CFG_IDX_W-1:0] idx,
                                       logic [yrh_pkg::CFG_DATA_W-1:0] d);
    dir_row_t r;
    r = tick_row(0, 1'b0, 0, 0);
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : int'($urandom_range(0, 4));
  endfunction

  // mostly engaged ticks with a drifting rate; the rest trip a disengage path
  function automatic yrh_pkg::in_item_t random_tick();
    yrh_pkg::in_item_t t;
    int mag, yaw;
    t.rate_valid = ($urandom_range(0, 15) != 0);
    t.wheel_pulse_sum = ($urandom_range(0, 9) != 0) ?
                        16'($urandom_range(int'(stop_lim), 65535)) : 16'($urandom);
    if ($urandom_range(0, 9) != 0) begin
      mag = $urandom_range(0, int'(turn_lim));
      t.turn_command = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
    end else begin
      t.turn_command = 16'($urandom);
    end
    case ($urandom_range(0, 7))
      0: yaw = int'($urandom_range(0, 16)) - 8;
      1: yaw = int'($urandom_range(0, 600)) - 300;
      2: yaw = int'($signed(16'($urandom)));
      3: yaw = $urandom_range(0, 1) ? 32767 : -32768;
      default: begin
        yaw = yaw_walk + int'($urandom_range(0, 64)) - 32;
        if (yaw > 32767) yaw = 32767;
        if (yaw < -32768) yaw = -32768;
      end
    endcase
    yaw_walk = yaw;
    t.yaw_rate = 16'(yaw);
    return t;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic drive_tick(yrh_pkg::in_item_t t, bit typed, yrh_pkg::out_item_t want);
    yrh_pkg::out_item_t guess;
    repeat (draw_gap()) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    guess = predict_tick(t);
    expected_outs.push_back(typed ? want : guess);
    ticks_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_outs.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [yrh_pkg::CFG_IDX_W-1:0] idx,
                           logic [yrh_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, d);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_phase(int ph);
    logic [yrh_pkg::CFG_DATA_W-1:0] vals [8];
    case (ph)
      0: vals = '{yrh_pkg::RST_HOLD_ENABLE, yrh_pkg::RST_GAIN_P, yrh_pkg::RST_GAIN_I,
                  yrh_pkg::RST_GAIN_D, yrh_pkg::RST_INTEGRAL_LIMIT,
                  yrh_pkg::RST_OUTPUT_LIMIT, yrh_pkg::RST_STOP_PULSES,
                  yrh_pkg::RST_TURN_THRESHOLD};
      1: vals = '{1, 65535, 65535, 65535, 2097151, 32767, 65535, 32767};
      2: vals = '{1, 0, 0, 0, 0, 0, 0, 0};
      default: begin
        vals[0] = 1;
        vals[1] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16384);
        vals[2] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8192);
        vals[3] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096);
        vals[4] = $urandom_range(0, 2097151);
        vals[5] = $urandom_range(0, 32767);
        vals[6] = $urandom_range(0, 8);
        vals[7] = $urandom_range(0, 3000);
      end
    endcase
    wait_idle();
    if (ph >= 3) begin
      write_reg(yrh_pkg::CFG_HOLD_ENABLE, 0);
      write_reg(CFG_IDX_SPARE, $urandom);
    end
    for (int i = 0; i < 8; i++) write_reg(yrh_pkg::cfg_idx_t'(i), vals[i]);
  endtask

  // result side: random stalls between transfers
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = draw_gap();
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_outs.size() == 0) begin
        report_mismatch("result with nothing pending, engaged", out_data.engaged, 0);
      end else begin
        oldest = expected_outs.pop_front();
        results_seen++;
        if (oldest.engaged) engaged_seen++;
        if (out_data.correction !== oldest.correction)
          report_mismatch("correction", longint'($signed(out_data.correction)),
                          longint'($signed(oldest.correction)));
        if (out_data.angle_error_deg !== oldest.angle_error_deg)
          report_mismatch("angle_error_deg", longint'($signed(out_data.angle_error_deg)),
                          longint'($signed(oldest.angle_error_deg)));
        if (out_data.engaged !== oldest.engaged)
          report_mismatch("engaged", out_data.engaged, oldest.engaged);
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    no_gaps = 1'b0;
    yaw_walk = 0;
    hold_en = yrh_pkg::RST_HOLD_ENABLE;
    kp = yrh_pkg::RST_GAIN_P;
    ki = yrh_pkg::RST_GAIN_I;
    kd = yrh_pkg::RST_GAIN_D;
    int_lim = yrh_pkg::RST_INTEGRAL_LIMIT;
    out_lim = yrh_pkg::RST_OUTPUT_LIMIT;
    stop_lim = yrh_pkg::RST_STOP_PULSES;
    turn_lim = yrh_pkg::RST_TURN_THRESHOLD;
    heading_int = 0;
    last_err = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: disengage paths and the deadzone edges
    rows.push_back(tick_row(0, 1, 0, 3, 1'b1, 0, 0, 1'b1));
    rows.push_back(tick_row(100, 0, 0, 1000, 1'b1));
    rows.push_back(tick_row(100, 1, 0, 2, 1'b1));
    rows.push_back(tick_row(100, 1, 83, 10, 1'b1));
    rows.push_back(tick_row(100, 1, -83, 10, 1'b1));
    rows.push_back(tick_row(100, 1, -32768, 10, 1'b1));
    rows.push_back(tick_row(7, 1, 82, 3));
    rows.push_back(tick_row(-7, 1, -82, 65535));
    rows.push_back(tick_row(8, 1, 0, 3));
    rows.push_back(tick_row(-8, 1, 0, 3));
    rows.push_back(tick_row(-32768, 1, 0, 3));
    rows.push_back(tick_row(32767, 1, 0, 3));
    // all gains zero, wide output: the integral alone runs into the integral clamp
    rows.push_back(cfg_row(yrh_pkg::CFG_GAIN_P, 0));
    rows.push_back(cfg_row(yrh_pkg::CFG_GAIN_I, 0));
    rows.push_back(cfg_row(yrh_pkg::CFG_GAIN_D, 0));
    rows.push_back(cfg_row(yrh_pkg::CFG_OUTPUT_LIMIT, 32767));
    repeat (4) rows.push_back(tick_row(-32768, 1, 0, 3));
    rows.push_back(tick_row(32767, 1, 0, 3));
    // zero limits, upper data bits set to exercise masking
    rows.push_back(cfg_row(yrh_pkg::CFG_INTEGRAL_LIMIT, 0));
    rows.push_back(cfg_row(yrh_pkg::CFG_OUTPUT_LIMIT, 32'hFFFF_8000));
    rows.push_back(cfg_row(yrh_pkg::CFG_GAIN_P, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(yrh_pkg::CFG_GAIN_I, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(yrh_pkg::CFG_GAIN_D, 32'hFFFF_FFFF));
    rows.push_back(tick_row(-32768, 1, 0, 3));
    rows.push_back(tick_row(32767, 1, 0, 3));
    // small integral limit: the undo step lands outside the clamp
    rows.push_back(cfg_row(yrh_pkg::CFG_INTEGRAL_LIMIT, 1000));
    rows.push_back(tick_row(-1000, 1, 0, 3));
    rows.push_back(cfg_row(CFG_IDX_SPARE, 32'h1234_5678));
    rows.push_back(cfg_row(yrh_pkg::CFG_HOLD_ENABLE, 0));
    rows.push_back(tick_row(5, 1, 0, 100, 1'b1));
    rows.push_back(cfg_row(yrh_pkg::CFG_HOLD_ENABLE, 1));
    rows.push_back(cfg_row(yrh_pkg::CFG_STOP_PULSES, 65535));
    rows.push_back(cfg_row(yrh_pkg::CFG_TURN_THRESHOLD, 0));
    rows.push_back(cfg_row(yrh_pkg::CFG_INTEGRAL_LIMIT, 2097151));
    rows.push_back(cfg_row(yrh_pkg::CFG_OUTPUT_LIMIT, 32767));
    rows.push_back(tick_row(-32768, 1, 0, 65535));
    rows.push_back(tick_row(1, 1, 0, 65534, 1'b1));
    rows.push_back(tick_row(1, 1, 1, 65535, 1'b1));
    rows.push_back(tick_row(-32768, 1, 0, 65535));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        drive_tick(rows[i].tick, rows[i].typed, rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      no_gaps = (ph == 1 || ph == 4);
      load_phase(ph);
      repeat (RANDOM_TICKS / PHASES) drive_tick(random_tick(), 1'b0, '0);
    end

    wait_idle();
    repeat (LATENCY * 4) @(posedge clk);
    $display("Sent %0d ticks over %0d register settings phases, %0d register writes",
             ticks_sent, PHASES + 1, cfg_writes);
    $display("Checked %0d results (%0d engaged), %0d mismatches",
             results_seen, engaged_seen, mismatches);
    if (mismatches == 0 && expected_outs.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/yrh_pkg.sv
sv/yaw_rate_hold_pid.sv
verif/tb_top.sv
